[rtl/core/dml_pkg.sv]
// ----------------------------------------------------------------------------
// dml_pkg
// Shared constants for the maximal munch DFA lexer: action codes, field
// widths, sequencer state codes and parameter defaults.
// ----------------------------------------------------------------------------
package dml_pkg;

    localparam int DEF_NUM_STATES  = 256;
    localparam int DEF_MAX_WORD    = 32;
    localparam int DEF_NUM_CLASSES = 64;

    localparam int ACTION_W = 2;
    localparam int STATE_FW = 8;
    localparam int CHAR_W   = 8;
    localparam int CLASS_W  = 6;
    localparam int START_W  = 5;
    localparam int LENGTH_W = 6;
    localparam int ACC_W    = CLASS_W + 1;

    localparam logic [ACTION_W-1:0] ACT_LOAD_TRANS  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD_ACCEPT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CHAR        = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_END_WORD    = 2'd3;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PASS = 3'd1;
    localparam logic [2:0] S_CHR  = 3'd2;
    localparam logic [2:0] S_TRN  = 3'd3;
    localparam logic [2:0] S_ACC  = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

endpackage

[rtl/core/dml_req_if.sv]
// ----------------------------------------------------------------------------
// dml_req_if
// Input item channel: valid/ready handshake with the item fields.
// ----------------------------------------------------------------------------
interface dml_req_if;
    logic                            valid;
    logic                            ready;
    logic [dml_pkg::ACTION_W-1:0]    action;
    logic [dml_pkg::STATE_FW-1:0]    from_state;
    logic [dml_pkg::CHAR_W-1:0]      char_code;
    logic [dml_pkg::STATE_FW-1:0]    to_state;
    logic                            entry_valid;
    logic [dml_pkg::CLASS_W-1:0]     token_class;

    modport source (output valid, action, from_state, char_code, to_state,
                    entry_valid, token_class, input ready);
    modport sink (input valid, action, from_state, char_code, to_state,
                  entry_valid, token_class, output ready);
endinterface

[rtl/core/dml_rsp_if.sv]
// ----------------------------------------------------------------------------
// dml_rsp_if
// Result channel: valid/ready handshake with the token fields.
// ----------------------------------------------------------------------------
interface dml_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            kind;
    logic [dml_pkg::CLASS_W-1:0]     class_out;
    logic [dml_pkg::START_W-1:0]     start_res;
    logic [dml_pkg::LENGTH_W-1:0]    length;
    logic [dml_pkg::CHAR_W-1:0]      error_char;
    logic                            joins_error;
    logic                            overflowed;
    logic                            last;

    modport source (output valid, kind, class_out, start_res, length, error_char,
                    joins_error, overflowed, last, input ready);
    modport sink (input valid, kind, class_out, start_res, length, error_char,
                  joins_error, overflowed, last, output ready);
endinterface

[rtl/core/dml_ram.sv]
// ----------------------------------------------------------------------------
// dml_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module dml_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/dml_ctrl.sv]
// ----------------------------------------------------------------------------
// dml_ctrl
// Item decode, table loads, word capture and the longest match scan
// sequencer with its output register.
// ----------------------------------------------------------------------------
module dml_ctrl #(
    parameter int NUM_STATES  = dml_pkg::DEF_NUM_STATES,
    parameter int MAX_WORD    = dml_pkg::DEF_MAX_WORD,
    parameter int NUM_CLASSES = dml_pkg::DEF_NUM_CLASSES,
    localparam int SW  = $clog2(NUM_STATES),
    localparam int TAW = SW + dml_pkg::CHAR_W,
    localparam int IW  = $clog2(MAX_WORD),
    localparam int LW  = $clog2(MAX_WORD + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         clr_busy,
    dml_req_if.sink                      req,
    dml_rsp_if.source                    rsp,
    output logic                         t_we,
    output logic [TAW-1:0]               t_waddr,
    output logic [SW:0]                  t_wdata,
    output logic [TAW-1:0]               t_raddr,
    input  logic [SW:0]                  t_rdata,
    output logic                         a_we,
    output logic [SW-1:0]                a_waddr,
    output logic [dml_pkg::ACC_W-1:0]    a_wdata,
    output logic [SW-1:0]                a_raddr,
    input  logic [dml_pkg::ACC_W-1:0]    a_rdata,
    output logic                         b_we,
    output logic [IW-1:0]                b_waddr,
    output logic [dml_pkg::CHAR_W-1:0]   b_wdata,
    output logic [IW-1:0]                b_raddr,
    input  logic [dml_pkg::CHAR_W-1:0]   b_rdata
);

    logic [2:0]                     state_reg, state_next;
    logic [LW-1:0]                  wlen_reg, wlen_next;
    logic                           ovf_reg, ovf_next;
    logic [LW-1:0]                  p_reg, p_next;
    logic [LW-1:0]                  i_reg, i_next;
    logic [LW-1:0]                  best_reg, best_next;
    logic [dml_pkg::CLASS_W-1:0]    cls_reg, cls_next;
    logic [SW-1:0]                  st_reg, st_next;
    logic [dml_pkg::CHAR_W-1:0]     errch_reg, errch_next;
    logic                           prev_err_reg, prev_err_next;
    logic                           ov_reg, ov_next;
    logic                           acc;
    logic                           emit;
    logic [LW-1:0]                  adv;
    logic [LW-1:0]                  p_adv;
    logic [LW-1:0]                  i_inc;
    logic                           no_match;

    assign req.ready = (state_reg == dml_pkg::S_IDLE) && !clr_busy;
    assign acc       = req.valid && req.ready;
    assign no_match  = (best_reg == '0);
    assign adv       = no_match ? LW'(1) : best_reg;
    assign p_adv     = p_reg + adv;
    assign i_inc     = i_reg + LW'(1);
    assign emit      = (state_reg == dml_pkg::S_EMIT) && (!ov_reg || rsp.ready);

    assign t_we    = acc && (req.action == dml_pkg::ACT_LOAD_TRANS)
                     && (32'(req.from_state) < NUM_STATES)
                     && (32'(req.to_state) < NUM_STATES);
    assign t_waddr = {SW'(req.from_state), req.char_code};
    assign t_wdata = req.entry_valid ? {1'b1, SW'(req.to_state)} : '0;

    assign a_we    = acc && (req.action == dml_pkg::ACT_LOAD_ACCEPT)
                     && (32'(req.from_state) < NUM_STATES)
                     && (32'(req.token_class) < NUM_CLASSES);
    assign a_waddr = SW'(req.from_state);
    assign a_wdata = req.entry_valid ? {1'b1, req.token_class} : '0;

    assign b_we    = acc && (req.action == dml_pkg::ACT_CHAR)
                     && (32'(wlen_reg) < MAX_WORD);
    assign b_waddr = wlen_reg[IW-1:0];
    assign b_wdata = req.char_code;

    assign t_raddr = {st_reg, b_rdata};
    assign a_raddr = t_rdata[SW-1:0];

    always_comb
    begin
        state_next    = state_reg;
        wlen_next     = wlen_reg;
        ovf_next      = ovf_reg;
        p_next        = p_reg;
        i_next        = i_reg;
        best_next     = best_reg;
        cls_next      = cls_reg;
        st_next       = st_reg;
        errch_next    = errch_reg;
        prev_err_next = prev_err_reg;
        b_raddr       = p_reg[IW-1:0];
        ov_next       = ov_reg && !rsp.ready;
        case (state_reg)
            dml_pkg::S_IDLE:
            begin
                if (acc && req.action == dml_pkg::ACT_CHAR)
                begin
                    if (32'(wlen_reg) < MAX_WORD)
                    begin
                        wlen_next = wlen_reg + LW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                else if (acc && req.action == dml_pkg::ACT_END_WORD)
                begin
                    if (wlen_reg == '0)
                    begin
                        ovf_next = 1'b0;
                    end
                    else
                    begin
                        p_next        = '0;
                        prev_err_next = 1'b0;
                        state_next    = dml_pkg::S_PASS;
                    end
                end
            end
            dml_pkg::S_PASS:
            begin
                b_raddr    = p_reg[IW-1:0];
                i_next     = p_reg;
                best_next  = '0;
                st_next    = '0;
                state_next = dml_pkg::S_CHR;
            end
            dml_pkg::S_CHR:
            begin
                if (i_reg == p_reg)
                begin
                    errch_next = b_rdata;
                end
                state_next = dml_pkg::S_TRN;
            end
            dml_pkg::S_TRN:
            begin
                if (t_rdata[SW])
                begin
                    st_next    = t_rdata[SW-1:0];
                    state_next = dml_pkg::S_ACC;
                end
                else
                begin
                    state_next = dml_pkg::S_EMIT;
                end
            end
            dml_pkg::S_ACC:
            begin
                if (a_rdata[dml_pkg::CLASS_W])
                begin
                    best_next = i_inc - p_reg;
                    cls_next  = a_rdata[dml_pkg::CLASS_W-1:0];
                end
                i_next  = i_inc;
                b_raddr = i_inc[IW-1:0];
                if (i_inc < wlen_reg)
                begin
                    state_next = dml_pkg::S_CHR;
                end
                else
                begin
                    state_next = dml_pkg::S_EMIT;
                end
            end
            dml_pkg::S_EMIT:
            begin
                if (emit)
                begin
                    ov_next       = 1'b1;
                    p_next        = p_adv;
                    prev_err_next = no_match;
                    if (p_adv >= wlen_reg)
                    begin
                        wlen_next  = '0;
                        ovf_next   = 1'b0;
                        state_next = dml_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_next = dml_pkg::S_PASS;
                    end
                end
            end
            default:
            begin
                state_next = dml_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= dml_pkg::S_IDLE;
            wlen_reg     <= '0;
            ovf_reg      <= 1'b0;
            prev_err_reg <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            wlen_reg     <= wlen_next;
            ovf_reg      <= ovf_next;
            prev_err_reg <= prev_err_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg     <= p_next;
        i_reg     <= i_next;
        best_reg  <= best_next;
        cls_reg   <= cls_next;
        st_reg    <= st_next;
        errch_reg <= errch_next;
        if (emit)
        begin
            rsp.kind        <= no_match;
            rsp.class_out   <= no_match ? '0 : cls_reg;
            rsp.start_res   <= dml_pkg::START_W'(p_reg);
            rsp.length      <= dml_pkg::LENGTH_W'(adv);
            rsp.error_char  <= no_match ? errch_reg : '0;
            rsp.joins_error <= no_match && prev_err_reg;
            rsp.overflowed  <= ovf_reg;
            rsp.last        <= (p_adv >= wlen_reg);
        end
    end

    assign rsp.valid = ov_reg;

endmodule

[rtl/core/dfa_maximal_munch_lexer.sv]
// ----------------------------------------------------------------------------
// dfa_maximal_munch_lexer
// Longest match tokenizer of buffered words against a loaded DFA.
// An end of word item scans each character with buffer, transition
// and accept RAM reads in turn (no accept read for the one that stops
// a pass), and all backtracked characters are rescanned.
// After reset a clearing pass empties both tables; no item is accepted
// meanwhile.
// ----------------------------------------------------------------------------
module dfa_maximal_munch_lexer #(
    parameter int NUM_STATES  = dml_pkg::DEF_NUM_STATES,
    parameter int MAX_WORD    = dml_pkg::DEF_MAX_WORD,
    parameter int NUM_CLASSES = dml_pkg::DEF_NUM_CLASSES
) (
    input  logic      clk,
    input  logic      rst_n,
    dml_req_if.sink   req,
    dml_rsp_if.source rsp
);

    localparam int SW  = $clog2(NUM_STATES);
    localparam int TAW = SW + dml_pkg::CHAR_W;
    localparam int IW  = $clog2(MAX_WORD);

    logic [TAW-1:0]               clr_cnt_reg;
    logic                         clr_busy_reg;
    logic                         c_t_we, c_a_we, c_b_we;
    logic [TAW-1:0]               c_t_waddr, t_waddr, t_raddr;
    logic [SW:0]                  c_t_wdata, t_wdata, t_rdata;
    logic [SW-1:0]                c_a_waddr, a_waddr, a_raddr;
    logic [dml_pkg::ACC_W-1:0]    c_a_wdata, a_wdata, a_rdata;
    logic [IW-1:0]                b_waddr, b_raddr;
    logic [dml_pkg::CHAR_W-1:0]   b_wdata, b_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else if (clr_busy_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + TAW'(1);
            if (clr_cnt_reg == '1)
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    assign t_waddr = clr_busy_reg ? clr_cnt_reg : c_t_waddr;
    assign t_wdata = clr_busy_reg ? '0 : c_t_wdata;
    assign a_waddr = clr_busy_reg ? clr_cnt_reg[SW-1:0] : c_a_waddr;
    assign a_wdata = clr_busy_reg ? '0 : c_a_wdata;

    dml_ctrl #(
        .NUM_STATES  (NUM_STATES),
        .MAX_WORD    (MAX_WORD),
        .NUM_CLASSES (NUM_CLASSES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .clr_busy (clr_busy_reg),
        .req      (req),
        .rsp      (rsp),
        .t_we     (c_t_we),
        .t_waddr  (c_t_waddr),
        .t_wdata  (c_t_wdata),
        .t_raddr  (t_raddr),
        .t_rdata  (t_rdata),
        .a_we     (c_a_we),
        .a_waddr  (c_a_waddr),
        .a_wdata  (c_a_wdata),
        .a_raddr  (a_raddr),
        .a_rdata  (a_rdata),
        .b_we     (c_b_we),
        .b_waddr  (b_waddr),
        .b_wdata  (b_wdata),
        .b_raddr  (b_raddr),
        .b_rdata  (b_rdata)
    );

    dml_ram #(.WIDTH(SW + 1), .DEPTH(2 ** TAW)) u_trans_ram (
        .clk   (clk),
        .we    (clr_busy_reg || c_t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    dml_ram #(.WIDTH(dml_pkg::ACC_W), .DEPTH(2 ** SW)) u_accept_ram (
        .clk   (clk),
        .we    (clr_busy_reg || c_a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    dml_ram #(.WIDTH(dml_pkg::CHAR_W), .DEPTH(MAX_WORD)) u_word_ram (
        .clk   (clk),
        .we    (c_b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

endmodule

[tb/dml_lex_checker.sv]
// ----------------------------------------------------------------------------
// dml_lex_checker
// Watches the item and result channels of the maximal munch lexer, keeps
// its own copy of the DFA tables and word buffer, predicts the tokens of
// every finished word and compares each result beat field by field.
// ----------------------------------------------------------------------------
module dml_lex_checker (
    input  logic clk,
    input  logic rst_n,
    dml_req_if   req,
    dml_rsp_if   rsp,
    output int   fail_count,
    output int   pending
);

    localparam int WIW = $clog2(dml_pkg::DEF_MAX_WORD);

    typedef struct packed {
        logic                         kind;
        logic [dml_pkg::CLASS_W-1:0]  cls;
        logic [dml_pkg::START_W-1:0]  start;
        logic [dml_pkg::LENGTH_W-1:0] len;
        logic [dml_pkg::CHAR_W-1:0]   echar;
        logic                         joins;
        logic                         ovf;
        logic                         last;
    } token_t;

    logic [8:0]                 trans_mem [0:65535];
    logic [dml_pkg::ACC_W-1:0]  accept_mem [0:255];
    logic [dml_pkg::CHAR_W-1:0] word_mem [0:dml_pkg::DEF_MAX_WORD-1];
    int                         word_len;
    logic                       word_ovf;
    token_t                     token_q [$];

    initial
    begin
        for (int i = 0; i < 65536; i++)
        begin
            trans_mem[i] = '0;
        end
        for (int i = 0; i < 256; i++)
        begin
            accept_mem[i] = '0;
        end
        word_len   = 0;
        word_ovf   = 1'b0;
        fail_count = 0;
    end

    assign pending = token_q.size();

    task automatic tokenize_word();
        token_t tokens [$];
        token_t tk;
        int     pos;
        logic [7:0] st;
        int     best;
        logic [dml_pkg::CLASS_W-1:0] best_cls;
        logic   prev_err;
        logic [8:0] t;
        pos      = 0;
        prev_err = 1'b0;
        while (pos < word_len && tokens.size() < dml_pkg::DEF_MAX_WORD)
        begin
            st       = '0;
            best     = 0;
            best_cls = '0;
            for (int i = pos; i < word_len; i++)
            begin
                t = trans_mem[{st, word_mem[i[WIW-1:0]]}];
                if (!t[8])
                    break;
                st = t[7:0];
                if (accept_mem[st][dml_pkg::CLASS_W])
                begin
                    best     = i - pos + 1;
                    best_cls = accept_mem[st][dml_pkg::CLASS_W-1:0];
                end
            end
            tk       = '0;
            tk.start = pos[dml_pkg::START_W-1:0];
            tk.ovf   = word_ovf;
            if (best > 0)
            begin
                tk.cls   = best_cls;
                tk.len   = best[dml_pkg::LENGTH_W-1:0];
                pos     += best;
                prev_err = 1'b0;
            end
            else
            begin
                tk.kind  = 1'b1;
                tk.len   = dml_pkg::LENGTH_W'(1);
                tk.echar = word_mem[pos[WIW-1:0]];
                tk.joins = prev_err;
                pos     += 1;
                prev_err = 1'b1;
            end
            tokens = {tokens, tk};
        end
        if (tokens.size() > 0)
        begin
            tokens[tokens.size() - 1].last = 1'b1;
        end
        token_q  = {token_q, tokens};
        word_len = 0;
        word_ovf = 1'b0;
    endtask

    always @(posedge clk)
    begin
        token_t ex;
        if (rst_n)
        begin
            if (req.valid && req.ready)
            begin
                case (req.action)
                    dml_pkg::ACT_LOAD_TRANS:
                        trans_mem[{req.from_state, req.char_code}] <=
                            req.entry_valid ? {1'b1, req.to_state} : 9'd0;
                    dml_pkg::ACT_LOAD_ACCEPT:
                        accept_mem[req.from_state] <=
                            req.entry_valid ? {1'b1, req.token_class} : '0;
                    dml_pkg::ACT_CHAR:
                    begin
                        if (word_len < dml_pkg::DEF_MAX_WORD)
                        begin
                            word_mem[word_len[WIW-1:0]] = req.char_code;
                            word_len++;
                        end
                        else
                            word_ovf = 1'b1;
                    end
                    default:
                        tokenize_word();
                endcase
            end
            if (rsp.valid && rsp.ready)
            begin
                if (token_q.size() == 0)
                begin
                    $error("unexpected result beat");
                    fail_count++;
                end
                else
                begin
                    ex = token_q.pop_front();
                    if (rsp.kind !== ex.kind)
                    begin
                        $error("kind: expected %0d, got %0d", ex.kind, rsp.kind);
                        fail_count++;
                    end
                    if (rsp.class_out !== ex.cls)
                    begin
                        $error("class_out: expected %0d, got %0d", ex.cls,
                               rsp.class_out);
                        fail_count++;
                    end
                    if (rsp.start_res !== ex.start)
                    begin
                        $error("start_res: expected %0d, got %0d", ex.start,
                               rsp.start_res);
                        fail_count++;
                    end
                    if (rsp.length !== ex.len)
                    begin
                        $error("length: expected %0d, got %0d", ex.len, rsp.length);
                        fail_count++;
                    end
                    if (rsp.error_char !== ex.echar)
                    begin
                        $error("error_char: expected %0d, got %0d", ex.echar,
                               rsp.error_char);
                        fail_count++;
                    end
                    if (rsp.joins_error !== ex.joins)
                    begin
                        $error("joins_error: expected %0d, got %0d", ex.joins,
                               rsp.joins_error);
                        fail_count++;
                    end
                    if (rsp.overflowed !== ex.ovf)
                    begin
                        $error("overflowed: expected %0d, got %0d", ex.ovf,
                               rsp.overflowed);
                        fail_count++;
                    end
                    if (rsp.last !== ex.last)
                    begin
                        $error("last: expected %0d, got %0d", ex.last, rsp.last);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

[tb/dfa_maximal_munch_lexer_tb.sv]
// ----------------------------------------------------------------------------
// dfa_maximal_munch_lexer_tb
// Loads DFAs, feeds words of directed and random content with random gaps
// and result stalls, and lets the checker compare every token beat.
// ----------------------------------------------------------------------------
module dfa_maximal_munch_lexer_tb;

    localparam int IDLE_LIMIT = 300000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    int   items_sent;
    int   stall_left;
    logic no_gaps;

    dml_req_if req ();
    dml_rsp_if rsp ();

    dfa_maximal_munch_lexer u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    dml_lex_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n           = 1'b0;
        req.valid       = 1'b0;
        req.action      = dml_pkg::ACT_LOAD_TRANS;
        req.from_state  = '0;
        req.char_code   = '0;
        req.to_state    = '0;
        req.entry_valid = 1'b0;
        req.token_class = '0;
        rsp.ready       = 1'b0;
        stall_left      = 0;
        no_gaps         = 1'b0;
        items_sent      = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                stall_left = no_gaps ? 0 : $urandom_range(0, 11);
                rsp.ready <= (stall_left == 0);
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp.ready <= (stall_left == 0);
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial idle_cycles = 0;

    task automatic send_beat(logic [dml_pkg::ACTION_W-1:0] act, logic [7:0] from_s,
                             logic [7:0] ch, logic [7:0] to_s, logic ev,
                             logic [dml_pkg::CLASS_W-1:0] cls);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid       <= 1'b1;
        req.action      <= act;
        req.from_state  <= from_s;
        req.char_code   <= ch;
        req.to_state    <= to_s;
        req.entry_valid <= ev;
        req.token_class <= cls;
        do @(posedge clk); while (!req.ready);
        items_sent++;
        if (items_sent % 20 == 0)
            no_gaps = ($urandom_range(0, 3) == 0);
    endtask

    task automatic load_trans(logic [7:0] from_s, logic [7:0] ch, logic [7:0] to_s,
                              logic ev);
        send_beat(dml_pkg::ACT_LOAD_TRANS, from_s, ch, to_s, ev,
                  dml_pkg::CLASS_W'($urandom));
    endtask

    task automatic load_accept(logic [7:0] st, logic [dml_pkg::CLASS_W-1:0] cls,
                               logic ev);
        send_beat(dml_pkg::ACT_LOAD_ACCEPT, st, 8'($urandom), 8'($urandom), ev, cls);
    endtask

    task automatic put_char(logic [7:0] ch);
        send_beat(dml_pkg::ACT_CHAR, 8'($urandom), ch, 8'($urandom), 1'($urandom),
                  dml_pkg::CLASS_W'($urandom));
    endtask

    task automatic end_word();
        send_beat(dml_pkg::ACT_END_WORD, 8'($urandom), 8'($urandom), 8'($urandom),
                  1'($urandom), dml_pkg::CLASS_W'($urandom));
    endtask

    function automatic logic [7:0] pick_char();
        return ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                           : 8'(8'h61 + $urandom_range(0, 3));
    endfunction

    function automatic logic [7:0] pick_state();
        return ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
    endfunction

    initial
    begin
        int wlen;
        int r;
        @(posedge rst_n);
        @(posedge clk);
        // a -> 1 (class 5), ab -> 2 (not accepting), aba -> 3 (class 63)
        load_trans(8'd0, 8'h61, 8'd1, 1'b1);
        load_trans(8'd1, 8'h62, 8'd2, 1'b1);
        load_trans(8'd2, 8'h61, 8'd3, 1'b1);
        load_accept(8'd1, 6'd5, 1'b1);
        load_accept(8'd3, 6'd63, 1'b1);
        load_accept(8'd0, 6'd9, 1'b1);
        load_trans(8'd255, 8'hff, 8'd255, 1'b1);
        load_trans(8'd0, 8'h00, 8'd255, 1'b1);
        load_accept(8'd255, 6'd0, 1'b1);
        put_char(8'h61); put_char(8'h62); put_char(8'h61); put_char(8'h61);
        end_word();
        put_char(8'h61); put_char(8'h62); put_char(8'h7a); put_char(8'h7a);
        end_word();
        end_word();
        put_char(8'h00); put_char(8'hff); put_char(8'h62);
        end_word();
        load_trans(8'd0, 8'h00, 8'd0, 1'b0);
        load_accept(8'd3, 6'd0, 1'b0);
        for (int i = 0; i < 34; i++)
        begin
            put_char(i[0] ? 8'h62 : 8'h61);
        end
        end_word();
        while (items_sent < 370)
        begin
            r = $urandom_range(0, 9);
            if (r < 3)
                load_trans(pick_state(), pick_char(), pick_state(),
                           $urandom_range(0, 5) != 0);
            else if (r < 5)
                load_accept(pick_state(), dml_pkg::CLASS_W'($urandom),
                            $urandom_range(0, 3) != 0);
            else
            begin
                r = $urandom_range(0, 19);
                wlen = (r == 0) ? 0 : (r == 1) ? $urandom_range(30, 36) : $urandom_range(1, 8);
                for (int i = 0; i < wlen; i++)
                begin
                    put_char(pick_char());
                end
                end_word();
            end
        end
        req.valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (3000) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
